// ----- rtl/tkhc_pkg.sv -----
// ----------------------------------------------------------------------------
// tkhc_pkg
// Shared widths, constants, register codes and the command/status types that
// join the tuple key hash controller and datapath.
// ----------------------------------------------------------------------------
package tkhc_pkg;

	localparam int DATA_W          = 32;
	localparam int HASH_W          = 64;
	localparam int CFG_DATA_W      = 32;
	localparam int CFG_IDX_W       = 1;
	localparam int COUNT_W         = 5;
	localparam int MAX_COLUMNS_DEF = 16;

	localparam logic [DATA_W-1:0] MIX_MUL = 32'h045d_9f3b;
	localparam logic [DATA_W-1:0] GOLDEN  = 32'h9e37_79b9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;    // take the input value, start seeds on a new tuple
		logic mul_first;  // first shift-xor-multiply of the mixer
		logic mul_second; // second shift-xor-multiply of the mixer
		logic fold;       // finish the mix and fold into both seeds
		logic short_step; // one or two column handling
		logic load_out;   // move the pending result into the output register
	} tkhc_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic cnt_zero;   // no column of the current tuple taken yet
		logic n_one;      // effective count is one
		logic n_two;      // effective count is two
		logic last;       // the column being folded completes the tuple
		logic out_free;   // output register can take a result this cycle
	} tkhc_stat_t;

endpackage

// ----- rtl/tkhc_datapath.sv -----
// ----------------------------------------------------------------------------
// tkhc_datapath
// Configuration registers, column counter, mixer, seed fold and output
// register of the tuple key hash combiner.
// ----------------------------------------------------------------------------
module tkhc_datapath #(
	parameter int MAX_COLUMNS = tkhc_pkg::MAX_COLUMNS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tkhc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tkhc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [tkhc_pkg::DATA_W-1:0]   column_value,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic signed [tkhc_pkg::HASH_W-1:0]   key_hash,
	input  tkhc_pkg::tkhc_cmd_t                  cmd,
	output tkhc_pkg::tkhc_stat_t                 stat
);

	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int DW    = tkhc_pkg::DATA_W;

	logic [DW-1:0]                     hash_seed_q;
	logic [tkhc_pkg::COUNT_W-1:0]      column_count_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [DW-1:0]                     val_q;
	logic [DW-1:0]                     mix_q;
	logic [DW-1:0]                     held_q;
	logic [DW-1:0]                     seed_hi_q;
	logic [DW-1:0]                     seed_lo_q;
	logic [tkhc_pkg::HASH_W-1:0]       res_q;
	logic [tkhc_pkg::HASH_W-1:0]       hash_q;
	logic                              out_valid_q;

	logic [DW-1:0] eff32;
	logic [DW-1:0] cnt_next32;
	logic [DW-1:0] pre_a;
	logic [DW-1:0] pre_b;
	logic [DW-1:0] mixed;
	logic [DW-1:0] fold_hi;
	logic [DW-1:0] fold_lo;

	// clamp the column count into one..MAX_COLUMNS
	always_comb begin
		if (column_count_q == '0) begin
			eff32 = 32'd1;
		end else if (32'(column_count_q) > 32'(MAX_COLUMNS)) begin
			eff32 = 32'(MAX_COLUMNS);
		end else begin
			eff32 = 32'(column_count_q);
		end
	end

	assign cnt_next32 = 32'(cnt_q) + 32'd1;

	// mixer stages: arithmetic shift-xor ahead of each multiply, golden add at end
	assign pre_a = $unsigned($signed(val_q) >>> 16) ^ val_q;
	assign pre_b = $unsigned($signed(mix_q) >>> 16) ^ mix_q;
	assign mixed = ($unsigned($signed(mix_q) >>> 16) ^ mix_q) + tkhc_pkg::GOLDEN;

	// hash_combine fold of both seeds, with an arithmetic right shift
	assign fold_hi = seed_hi_q ^ (mixed + (seed_hi_q << 6) + $unsigned($signed(seed_hi_q) >>> 2));
	assign fold_lo = seed_lo_q ^ (mixed + (seed_lo_q << 6) + $unsigned($signed(seed_lo_q) >>> 2));

	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.n_one    = (eff32 == 32'd1);
	assign stat.n_two    = (eff32 == 32'd2);
	assign stat.last     = (cnt_next32 >= eff32);
	assign stat.out_free = !out_valid_q || out_ready;

	// configuration registers, column counter and held first value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q    <= '0;
			column_count_q <= tkhc_pkg::COUNT_W'(1);
			cnt_q          <= '0;
			held_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tkhc_pkg::REG_HASH_SEED:    hash_seed_q <= cfg_data;
					tkhc_pkg::REG_COLUMN_COUNT:
						column_count_q <= cfg_data[tkhc_pkg::COUNT_W-1:0];
					default: ;
				endcase
				cnt_q <= '0;
			end else if (cmd.load_out) begin
				cnt_q <= '0;
			end else if (cmd.fold) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.short_step && !stat.n_one && stat.cnt_zero) begin
				held_q <= val_q;
				cnt_q  <= CNT_W'(1);
			end
		end
	end

	// working registers: value, mixer, seeds, pending result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			val_q <= column_value;
			if (stat.cnt_zero) begin
				seed_hi_q <= hash_seed_q;
				seed_lo_q <= hash_seed_q + eff32;
			end
		end
		if (cmd.mul_first) begin
			mix_q <= pre_a * tkhc_pkg::MIX_MUL;
		end
		if (cmd.mul_second) begin
			mix_q <= pre_b * tkhc_pkg::MIX_MUL;
		end
		if (cmd.fold) begin
			seed_hi_q <= fold_hi;
			seed_lo_q <= fold_lo;
			res_q     <= {fold_hi, fold_lo};
		end
		if (cmd.short_step) begin
			if (stat.n_one) begin
				res_q <= {{DW{val_q[DW-1]}}, val_q};
			end else begin
				res_q <= {held_q, val_q};
			end
		end
		if (cmd.load_out) begin
			hash_q <= res_q;
		end
	end

	// output valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign key_hash  = $signed(hash_q);

endmodule

// ----- rtl/tkhc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tkhc_ctrl
// Sequencer of the tuple key hash combiner: accepts one column value, steps
// it through the mixer and fold or the short path, and hands off the result once a tuple completes.
// ----------------------------------------------------------------------------
module tkhc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tkhc_pkg::tkhc_stat_t  stat,
	output tkhc_pkg::tkhc_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_FOLD,
		ST_SHORT,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	// decode commands from the current state
	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && in_valid;
		cmd.mul_first  = (state_q == ST_MUL1);
		cmd.mul_second = (state_q == ST_MUL2);
		cmd.fold       = (state_q == ST_FOLD);
		cmd.short_step = (state_q == ST_SHORT);
		cmd.load_out   = (state_q == ST_EMIT) && stat.out_free;
	end

	// advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (stat.n_one || stat.n_two) begin
							state_q <= ST_SHORT;
						end else begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FOLD;
				ST_FOLD: begin
					state_q <= stat.last ? ST_EMIT : ST_IDLE;
				end
				ST_SHORT: begin
					// hold the first of two columns, otherwise emit
					if (!stat.n_one && stat.cnt_zero) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/tuple_key_hash_combiner_unit.sv -----
// ----------------------------------------------------------------------------
// tuple_key_hash_combiner_unit
// Combines the key column values of a tuple into one 64-bit key hash.
// ----------------------------------------------------------------------------
// Usage:
//   Column values enter on the in channel (in_valid/in_ready), one 32-bit
//   signed value per transfer, in column order. After the last column of a
//   tuple one key_hash leaves on the out channel (out_valid/out_ready).
//   Registers hash_seed (index 0) and column_count (index 1) are written
//   through cfg_we/cfg_index/cfg_data, by the user only while the unit is
//   idle, which the unit does not enforce; a write starts a fresh tuple.
//   Flow: the unit works on one value at a time. With three or more
//   columns a value passes two multiply steps of the shared mixer, then
//   the seed fold, plus a hand-off step for the hash on the last column.
//   With one column, or the second of two, a value takes the short step
//   and the hand-off step; the first of two takes the short step only.
//   Reset clears the registers to seed 0 and one column, and empties the
//   output register. When the receiver stalls, the hash waits in the output
//   register while the next value is still taken; the unit holds in its
//   hand-off step only if a second hash is ready before the first leaves.
// ----------------------------------------------------------------------------
module tuple_key_hash_combiner_unit #(
	parameter int MAX_COLUMNS = tkhc_pkg::MAX_COLUMNS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tkhc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tkhc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tkhc_pkg::DATA_W-1:0]  column_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tkhc_pkg::HASH_W-1:0]  key_hash
);

	tkhc_pkg::tkhc_cmd_t  cmd;
	tkhc_pkg::tkhc_stat_t stat;

	// sequencer
	tkhc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers, mixer and fold
	tkhc_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.column_value (column_value),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.key_hash     (key_hash),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

// ----- verif/tb_tuple_key_hash_combiner_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tuple_key_hash_combiner_unit
// Self-checking bench for the tuple key hash unit. Column values go in through
// a valid/ready channel with random gaps. A behavioral predictor computes the
// expected key hash of each complete tuple, and a monitor compares each hash
// transfer against the oldest prediction. Directed tests cover the one, two
// and many column paths, the field extremes, a zero count and a register
// write in the middle of a tuple. Random phases then sweep seeds and column
// counts, including saturated counts and partial tuples, under varied stalls.
// ----------------------------------------------------------------------------
module tb_tuple_key_hash_combiner_unit;

	localparam int RANDOM_ITEMS = 1800;
	localparam int MAX_GAP      = 17;
	localparam int SETTLE_CYCLES = 10;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [tkhc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tkhc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [tkhc_pkg::DATA_W-1:0]     column_value;
	logic                            out_valid;
	logic                            out_ready;
	logic [tkhc_pkg::HASH_W-1:0]     key_hash;

	tuple_key_hash_combiner_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.column_value (column_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_hash     (key_hash)
	);

	// predictor state: register copies and the tuple in progress
	logic [31:0] seed_reg;
	logic [4:0]  columns_reg;
	int unsigned columns_taken;
	logic [31:0] seed_high;
	logic [31:0] seed_low;
	logic [31:0] first_held;

	logic [tkhc_pkg::HASH_W-1:0] expected_hashes[$];
	logic [tkhc_pkg::HASH_W-1:0] wanted_hash;

	bit quiet_stretch;
	int error_count;
	int values_sent;
	int hashes_checked;
	int settings_used;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#6_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned sh);
		return $unsigned($signed(v) >>> sh);
	endfunction

	function automatic int unsigned eff_columns();
		if (columns_reg == 5'd0)
			return 1;
		if (columns_reg > tkhc_pkg::MAX_COLUMNS_DEF)
			return tkhc_pkg::MAX_COLUMNS_DEF;
		return columns_reg;
	endfunction

	function automatic logic [31:0] mix_value(input logic [31:0] v);
		logic [31:0] y;
		y = (sra32(v, 16) ^ v) * tkhc_pkg::MIX_MUL;
		y = (sra32(y, 16) ^ y) * tkhc_pkg::MIX_MUL;
		y = sra32(y, 16) ^ y;
		return y + tkhc_pkg::GOLDEN;
	endfunction

	function automatic logic [31:0] fold_seed(input logic [31:0] s, input logic [31:0] x);
		return s ^ (x + (s << 6) + sra32(s, 2));
	endfunction

	task automatic restart_tuple();
		columns_taken = 0;
		seed_high     = seed_reg;
		seed_low      = seed_reg + eff_columns();
	endtask

	// append one predicted hash behind the ones still outstanding
	task automatic queue_hash(input logic [tkhc_pkg::HASH_W-1:0] h);
		expected_hashes.insert(expected_hashes.size(), h);
	endtask

	// advance the predictor by one accepted column value
	task automatic predict_column(input logic [31:0] v);
		int unsigned n;
		logic [31:0] x;
		n = eff_columns();
		if (columns_taken == 0)
			restart_tuple();
		if (n == 1) begin
			queue_hash({{32{v[31]}}, v});
			restart_tuple();
		end else if (n == 2) begin
			if (columns_taken == 0) begin
				first_held    = v;
				columns_taken = 1;
			end else begin
				queue_hash({first_held, v});
				restart_tuple();
			end
		end else begin
			x = mix_value(v);
			seed_high = fold_seed(seed_high, x);
			seed_low  = fold_seed(seed_low, x);
			columns_taken++;
			if (columns_taken >= n) begin
				queue_hash({seed_high, seed_low});
				restart_tuple();
			end
		end
	endtask

	// ------------------------------------------------------------------ drivers

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// write one register; the predictor drops the partial tuple
	task automatic write_reg(input logic [tkhc_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			tkhc_pkg::REG_HASH_SEED:    seed_reg = data;
			tkhc_pkg::REG_COLUMN_COUNT: columns_reg = data[4:0];
			default: ;
		endcase
		restart_tuple();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// send one column value; valid stays high when no gap follows
	task automatic send_column(input logic [31:0] v);
		int gap;
		gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		column_value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		values_sent++;
		predict_column(v);
	endtask

	// drop valid, wait for every expected hash, then let the unit go quiet
	task automatic settle_unit();
		in_valid <= 1'b0;
		while (expected_hashes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [31:0] seed, input logic [31:0] count_word);
		settle_unit();
		write_reg(tkhc_pkg::REG_HASH_SEED, seed);
		write_reg(tkhc_pkg::REG_COLUMN_COUNT, count_word);
		settings_used++;
	endtask

	// receiver: draw a stall per hash, hold ready high when none is drawn
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// monitor: compare each hash transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_hashes.size() == 0) begin
				report_mismatch($sformatf("unexpected key_hash %h", key_hash));
			end else begin
				wanted_hash = expected_hashes.pop_front();
				hashes_checked++;
				if (key_hash !== wanted_hash)
					report_mismatch($sformatf("key_hash got %h want %h", key_hash,
						wanted_hash));
			end
		end
	end

	// -------------------------------------------------------------- stimulus

	function automatic logic [31:0] draw_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			4: return $urandom_range(0, 31) - 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] draw_seed();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// mostly small counts, with zero, the maximum and saturated counts now and then
	function automatic logic [4:0] draw_count();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 5'd0;
		if (r == 1) return 5'd16;
		if (r == 2) return 5'($urandom_range(17, 31));
		if (r <= 6) return 5'd1;
		if (r <= 10) return 5'd2;
		if (r <= 17) return 5'($urandom_range(3, 6));
		return 5'($urandom_range(7, 15));
	endfunction

	// one column at reset settings: sign extension and every bit both ways
	task automatic test_single_column();
		send_column(32'h0000_0000);
		send_column(32'hffff_ffff);
		send_column(32'h7fff_ffff);
		send_column(32'h8000_0000);
	endtask

	// two columns: upper and lower word, lower word negative
	task automatic test_two_columns();
		apply_setting(32'h1234_5678, 32'd2);
		send_column(32'h7fff_ffff);
		send_column(32'h8000_0000);
		send_column(32'h8000_0000);
		send_column(32'hffff_ffff);
	endtask

	// zero count acts as one; mixing path at the seed extremes
	task automatic test_mixed_columns();
		apply_setting(32'h7fff_ffff, 32'd0);
		send_column(32'h1234_5678);
		// upper data bits of the count word are ignored
		apply_setting(32'h8000_0000, 32'hffff_ffe3);
		send_column(32'h0000_0000);
		send_column(32'hffff_ffff);
		send_column(32'h8000_0000);
	endtask

	// a write in the middle of a tuple discards the columns taken so far
	task automatic test_mid_tuple_write();
		apply_setting(32'h7fff_ffff, 32'd4);
		send_column(32'hdead_beef);
		send_column(32'h0bad_f00d);
		settle_unit();
		write_reg(tkhc_pkg::REG_HASH_SEED, 32'h1357_9bdf);
		repeat (4) send_column($urandom);
	endtask

	// random phases of whole tuples, with partial tuples cut off by a write
	task automatic test_random_tuples();
		int start_count;
		int n;
		int tuples;
		logic [4:0] count;
		start_count = values_sent;
		while (values_sent - start_count < RANDOM_ITEMS) begin
			settle_unit();
			quiet_stretch = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0)
				write_reg(tkhc_pkg::REG_HASH_SEED, draw_seed());
			count = draw_count();
			write_reg(tkhc_pkg::REG_COLUMN_COUNT, ($urandom & 32'hffff_ffe0) | count);
			settings_used++;
			n = eff_columns();
			tuples = $urandom_range(1, 48 / n + 2);
			repeat (tuples)
				repeat (n) send_column(draw_value());
			if (n > 1 && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, n - 1)) send_column(draw_value());
		end
		quiet_stretch = 1'b0;
	endtask

	// ------------------------------------------------------------- main flow

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		column_value  = '0;
		quiet_stretch = 1'b0;
		error_count   = 0;
		values_sent   = 0;
		hashes_checked = 0;
		settings_used = 1;
		seed_reg      = 32'h0;
		columns_reg   = 5'd1;
		first_held    = 32'h0;
		restart_tuple();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_column();
		test_two_columns();
		test_mixed_columns();
		test_mid_tuple_write();
		test_random_tuples();

		settle_unit();
		if (expected_hashes.size() != 0)
			report_mismatch($sformatf("%0d hashes never arrived", expected_hashes.size()));

		$display("Sent %0d column values over %0d register settings;", values_sent,
			settings_used);
		$display("checked %0d key hashes, %0d mismatches.", hashes_checked, error_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/tkhc_pkg.sv
rtl/tkhc_datapath.sv
rtl/tkhc_ctrl.sv
rtl/tuple_key_hash_combiner_unit.sv
verif/tb_tuple_key_hash_combiner_unit.sv
